// ===== rtl/tiecc_pkg.sv =====
// Shared types, opcodes and sequencer states for the toy ISA execute unit.
// No dependencies; compile first.
package tiecc_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned STEP_W      = $clog2(DATA_W);
  localparam int unsigned CYC_W       = 48;
  localparam int unsigned FILL_CYCLES = 2;

  localparam logic [7:0] OP_SET  = 8'h00;
  localparam logic [7:0] OP_ADD  = 8'h10;
  localparam logic [7:0] OP_ADDI = 8'h11;
  localparam logic [7:0] OP_SUB  = 8'h20;
  localparam logic [7:0] OP_SUBI = 8'h21;
  localparam logic [7:0] OP_MUL  = 8'h30;
  localparam logic [7:0] OP_MULI = 8'h31;
  localparam logic [7:0] OP_DIV  = 8'h40;
  localparam logic [7:0] OP_DIVI = 8'h41;

  localparam logic [3:0] KIND_ADD = 4'h1;
  localparam logic [3:0] KIND_SUB = 4'h2;
  localparam logic [3:0] KIND_MUL = 4'h3;
  localparam logic [3:0] KIND_DIV = 4'h4;

  localparam logic [2:0] LAT_ALU = 3'd1;
  localparam logic [2:0] LAT_MUL = 3'd2;
  localparam logic [2:0] LAT_DIV = 3'd4;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_OPCODE   = 2'd1,
    ERR_RANGE    = 2'd2,
    ERR_DIV_ZERO = 2'd3
  } err_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ_X,
    S_READ_Y,
    S_LOAD_Y,
    S_ALU,
    S_MUL,
    S_DIV_CHK,
    S_ABS_X,
    S_ABS_Y,
    S_DIV,
    S_SIGN,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] dest_index;
    logic [7:0] src_index;
    logic [7:0] src_or_imm;
    logic       last_instr;
  } instr_t;

  typedef struct packed {
    logic                     wrote;
    logic [7:0]               written_reg;
    logic signed [DATA_W-1:0] written_value;
    logic [2:0]               latency;
    logic [CYC_W-1:0]         total_cycles;
    err_t                     error_code;
    logic                     program_done;
  } result_t;

  function automatic logic op_arith(input logic [7:0] op);
    return op == OP_ADD || op == OP_ADDI || op == OP_SUB || op == OP_SUBI ||
           op == OP_MUL || op == OP_MULI || op == OP_DIV || op == OP_DIVI;
  endfunction

  function automatic logic [2:0] op_latency(input logic [7:0] op);
    logic [2:0] lat;
    lat = LAT_ALU;
    if (op == OP_MUL || op == OP_MULI) lat = LAT_MUL;
    if (op == OP_DIV || op == OP_DIVI) lat = LAT_DIV;
    return lat;
  endfunction

endpackage

// ===== rtl/tiecc_if.sv =====
// Valid/ready channels for instructions and results.
// Depends on tiecc_pkg.
interface tiecc_instr_if;
  logic              valid;
  logic              ready;
  tiecc_pkg::instr_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tiecc_result_if;
  logic               valid;
  logic               ready;
  tiecc_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/toy_isa_execute_with_cycle_count_unit.sv =====
// Toy ISA execute unit: register file, shared-adder sequencer, cycle total.
// Depends on tiecc_pkg and the channel interfaces in tiecc_if.sv.
//
// Executes one instruction per transfer on instr and returns one result per
// transfer on result. The block works on one instruction at a time: instr.ready
// is high only while the sequencer is idle, and a finished result sits in an
// output register, so the next instruction is taken while that result still
// waits. All arithmetic runs through one 33-bit add/subtract unit under the
// sequencer. Set and opcode or range errors go straight to the finish state;
// add and sub read both operands and take one adder step; multiply does one
// shift-add bit per cycle; divide does a zero check (a divide by zero stops
// there), two magnitude steps, one restoring bit per cycle and a sign fix.
// The finish state holds while the result side stalls. The register file is a
// NUM_REGS-entry memory with one registered read port, read once per source
// operand; a valid bit per entry makes every register read as zero after
// reset, so no clearing pass is needed. Register numbers at or above NUM_REGS
// flag a range error. total_cycles starts at two and saturates at 2^48-1.
module toy_isa_execute_with_cycle_count_unit #(
  parameter int unsigned NUM_REGS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  tiecc_instr_if.sink           instr,
  tiecc_result_if.source        result
);
  import tiecc_pkg::*;

  localparam int unsigned IDX_W      = $clog2(NUM_REGS);
  localparam logic [8:0]  NUM_REGS_L = 9'(NUM_REGS);

  // sequencer
  state_t state, state_next;

  // latched instruction
  logic [7:0]  op_q;
  logic [7:0]  d_q;
  logic [7:0]  a_q;
  logic [7:0]  b_q;
  logic        last_q;
  logic        imm_q;
  logic [2:0]  lat_q;
  err_t        err_q;
  err_t        dec_err;

  // datapath
  logic [DATA_W-1:0] x;
  logic [DATA_W-1:0] y;
  logic [DATA_W-1:0] acc;
  logic              neg;
  logic [STEP_W-1:0] cnt;

  // shared adder
  logic [DATA_W:0]   add_a;
  logic [DATA_W:0]   add_b;
  logic              add_sub;
  logic [DATA_W+1:0] add_sum;

  // register file
  logic [DATA_W-1:0] rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld;
  logic [IDX_W-1:0]  rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic              rd_hit;
  logic [DATA_W-1:0] rd_val;

  // cycle total and output register
  logic [CYC_W-1:0]  cyc_total;
  logic [CYC_W:0]    cyc_sum;
  logic [CYC_W-1:0]  cyc_next;
  logic              out_vld;
  result_t           out_data;
  logic              out_free;
  logic              accept;
  logic              fin_go;

  assign accept   = instr.valid && instr.ready;
  assign out_free = !out_vld || result.ready;
  assign fin_go   = (state == S_FIN) && out_free;

  assign result.valid = out_vld;
  assign result.data  = out_data;

  // Decode errors known at transfer time: opcode, then register range.
  always_comb begin
    dec_err = ERR_NONE;
    if (instr.data.opcode == OP_SET) begin
      if ({1'b0, instr.data.dest_index} >= NUM_REGS_L) dec_err = ERR_RANGE;
    end else if (op_arith(instr.data.opcode)) begin
      if ({1'b0, instr.data.dest_index} >= NUM_REGS_L ||
          {1'b0, instr.data.src_index} >= NUM_REGS_L ||
          (instr.data.opcode[3:0] != 4'h1 &&
           {1'b0, instr.data.src_or_imm} >= NUM_REGS_L)) begin
        dec_err = ERR_RANGE;
      end
    end else begin
      dec_err = ERR_OPCODE;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (dec_err != ERR_NONE || instr.data.opcode == OP_SET) state_next = S_FIN;
          else state_next = S_READ_X;
        end
      end
      S_READ_X: state_next = S_READ_Y;
      S_READ_Y: state_next = S_LOAD_Y;
      S_LOAD_Y: begin
        unique case (op_q[7:4])
          KIND_ADD, KIND_SUB: state_next = S_ALU;
          KIND_MUL:           state_next = S_MUL;
          KIND_DIV:           state_next = S_DIV_CHK;
          default:            state_next = S_FIN;
        endcase
      end
      S_ALU:     state_next = S_FIN;
      S_MUL:     if (cnt == STEP_W'(DATA_W - 1)) state_next = S_FIN;
      S_DIV_CHK: state_next = (y == '0) ? S_FIN : S_ABS_X;
      S_ABS_X:   state_next = S_ABS_Y;
      S_ABS_Y:   state_next = S_DIV;
      S_DIV:     if (cnt == STEP_W'(DATA_W - 1)) state_next = S_SIGN;
      S_SIGN:    state_next = S_FIN;
      S_FIN:     if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, read address, adder operands.
  always_comb begin
    instr.ready = 1'b0;
    rd_addr     = a_q[IDX_W-1:0];
    add_a       = '0;
    add_b       = '0;
    add_sub     = 1'b0;
    unique case (state)
      S_IDLE:   instr.ready = 1'b1;
      S_READ_X: rd_addr = a_q[IDX_W-1:0];
      S_READ_Y: rd_addr = b_q[IDX_W-1:0];
      S_ALU: begin
        add_a   = {1'b0, x};
        add_b   = {1'b0, y};
        add_sub = (op_q[7:4] == KIND_SUB);
      end
      S_MUL: begin
        add_a = {1'b0, acc};
        add_b = {1'b0, x};
      end
      S_ABS_X, S_SIGN: begin
        add_b   = {1'b0, x};
        add_sub = 1'b1;
      end
      S_ABS_Y: begin
        add_b   = {1'b0, y};
        add_sub = 1'b1;
      end
      S_DIV: begin
        add_a   = {acc, x[DATA_W-1]};
        add_b   = {1'b0, y};
        add_sub = 1'b1;
      end
      default: ;
    endcase
  end

  // Carry out high on subtract means no borrow.
  assign add_sum = {1'b0, add_a} + {1'b0, add_sub ? ~add_b : add_b} + (DATA_W+2)'(add_sub);

  assign rd_val   = rd_hit ? rd_data : '0;
  assign cyc_sum  = {1'b0, cyc_total} + (CYC_W+1)'(lat_q);
  assign cyc_next = cyc_sum[CYC_W] ? '1 : cyc_sum[CYC_W-1:0];

  // Register file: one registered read port, one write port.
  always_ff @(posedge clk) begin
    rd_data <= rf_mem[rd_addr];
    rd_hit  <= rf_vld[rd_addr];
    if (fin_go && err_q == ERR_NONE) rf_mem[d_q[IDX_W-1:0]] <= acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld <= '0;
    end else if (fin_go && err_q == ERR_NONE) begin
      rf_vld[d_q[IDX_W-1:0]] <= 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cyc_total <= CYC_W'(FILL_CYCLES);
      out_vld   <= 1'b0;
    end else begin
      state <= state_next;
      if (fin_go) begin
        cyc_total <= cyc_next;
        out_vld   <= 1'b1;
      end else if (result.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  // Datapath and latched instruction.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op_q   <= instr.data.opcode;
          d_q    <= instr.data.dest_index;
          a_q    <= instr.data.src_index;
          b_q    <= instr.data.src_or_imm;
          last_q <= instr.data.last_instr;
          imm_q  <= (instr.data.opcode[3:0] == 4'h1);
          lat_q  <= op_latency(instr.data.opcode);
          err_q  <= dec_err;
          acc    <= {{(DATA_W-8){1'b0}}, instr.data.src_index};
        end
      end
      S_READ_Y: x <= rd_val;
      S_LOAD_Y: begin
        y   <= imm_q ? {{(DATA_W-8){1'b0}}, b_q} : rd_val;
        acc <= '0;
        cnt <= '0;
      end
      S_ALU: acc <= add_sum[DATA_W-1:0];
      S_MUL: begin
        if (y[0]) acc <= add_sum[DATA_W-1:0];
        x   <= {x[DATA_W-2:0], 1'b0};
        y   <= {1'b0, y[DATA_W-1:1]};
        cnt <= cnt + 1'b1;
      end
      S_DIV_CHK: begin
        if (y == '0) err_q <= ERR_DIV_ZERO;
        neg <= x[DATA_W-1] ^ (!imm_q && y[DATA_W-1]);
      end
      S_ABS_X: if (x[DATA_W-1]) x <= add_sum[DATA_W-1:0];
      S_ABS_Y: begin
        if (!imm_q && y[DATA_W-1]) y <= add_sum[DATA_W-1:0];
        acc <= '0;
        cnt <= '0;
      end
      S_DIV: begin
        // restoring step: keep the difference when it does not borrow
        if (add_sum[DATA_W+1]) acc <= add_sum[DATA_W-1:0];
        else acc <= {acc[DATA_W-2:0], x[DATA_W-1]};
        x   <= {x[DATA_W-2:0], add_sum[DATA_W+1]};
        cnt <= cnt + 1'b1;
      end
      S_SIGN: acc <= neg ? add_sum[DATA_W-1:0] : x;
      S_FIN: begin
        if (out_free) begin
          out_data.wrote         <= (err_q == ERR_NONE);
          out_data.written_reg   <= (err_q == ERR_NONE) ? d_q : 8'd0;
          out_data.written_value <= (err_q == ERR_NONE) ? $signed(acc) : '0;
          out_data.latency       <= lat_q;
          out_data.total_cycles  <= cyc_next;
          out_data.error_code    <= err_q;
          out_data.program_done  <= last_q;
        end
      end
      default: ;
    endcase
  end

  // Checks.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("sequencer stayed idle after an instruction transfer");

  a_write_is_clean: assert property (@(posedge clk) disable iff (rst)
    out_vld && out_data.wrote |->
      out_data.error_code == ERR_NONE && {1'b0, out_data.written_reg} < NUM_REGS_L)
    else $error("register write reported with an error or bad index");

  a_div_zero_latency: assert property (@(posedge clk) disable iff (rst)
    out_vld && out_data.error_code == ERR_DIV_ZERO |-> out_data.latency == LAT_DIV)
    else $error("divide by zero reported with wrong latency");

  a_total_floor: assert property (@(posedge clk) disable iff (rst)
    cyc_total >= CYC_W'(FILL_CYCLES))
    else $error("cycle total below fill cycles");

  a_fin_loads_output: assert property (@(posedge clk) disable iff (rst)
    fin_go |=> out_vld && state == S_IDLE)
    else $error("finished instruction did not reach the output register");

endmodule
